@@ hw/rtl/mi3_pkg.sv @@
`default_nettype none
package mi3_pkg;

  // Default element format.
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef logic [3:0] elem_idx_t;

  // For each output element: cofactor = m[a]*m[b] - m[c]*m[d], with the
  // cofactor sign and the transpose already folded in.
  localparam elem_idx_t COF_TAB [9][4] = '{
    '{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd7, 4'd2, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd4, 4'd2},
    '{4'd6, 4'd5, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd6, 4'd2}, '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd3, 4'd1}
  };

endpackage
`default_nettype wire

@@ hw/rtl/mi3_if.sv @@
`default_nettype none
// Matrix input channel.
interface mi3_in_if #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [ELEM_WIDTH-1:0] in_c0_r0;
  logic signed [ELEM_WIDTH-1:0] in_c0_r1;
  logic signed [ELEM_WIDTH-1:0] in_c0_r2;
  logic signed [ELEM_WIDTH-1:0] in_c1_r0;
  logic signed [ELEM_WIDTH-1:0] in_c1_r1;
  logic signed [ELEM_WIDTH-1:0] in_c1_r2;
  logic signed [ELEM_WIDTH-1:0] in_c2_r0;
  logic signed [ELEM_WIDTH-1:0] in_c2_r1;
  logic signed [ELEM_WIDTH-1:0] in_c2_r2;

  modport source (output valid, in_c0_r0, in_c0_r1, in_c0_r2, in_c1_r0, in_c1_r1,
                  in_c1_r2, in_c2_r0, in_c2_r1, in_c2_r2, input ready);
  modport sink (input valid, in_c0_r0, in_c0_r1, in_c0_r2, in_c1_r0, in_c1_r1,
                in_c1_r2, in_c2_r0, in_c2_r1, in_c2_r2, output ready);
endinterface

// Inverse result channel.
interface mi3_out_if #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [ELEM_WIDTH-1:0] out_c0_r0;
  logic signed [ELEM_WIDTH-1:0] out_c0_r1;
  logic signed [ELEM_WIDTH-1:0] out_c0_r2;
  logic signed [ELEM_WIDTH-1:0] out_c1_r0;
  logic signed [ELEM_WIDTH-1:0] out_c1_r1;
  logic signed [ELEM_WIDTH-1:0] out_c1_r2;
  logic signed [ELEM_WIDTH-1:0] out_c2_r0;
  logic signed [ELEM_WIDTH-1:0] out_c2_r1;
  logic signed [ELEM_WIDTH-1:0] out_c2_r2;
  logic singular;
  logic saturated;

  modport source (output valid, out_c0_r0, out_c0_r1, out_c0_r2, out_c1_r0, out_c1_r1,
                  out_c1_r2, out_c2_r0, out_c2_r1, out_c2_r2, singular, saturated,
                  input ready);
  modport sink (input valid, out_c0_r0, out_c0_r1, out_c0_r2, out_c1_r0, out_c1_r1,
                out_c1_r2, out_c2_r0, out_c2_r1, out_c2_r2, singular, saturated,
                output ready);
endinterface
`default_nettype wire

@@ hw/rtl/matrix3_inverse.sv @@
`default_nettype none
// Throughput: one matrix per cycle unless the sink stalls; the quotient is formed by ELEM_WIDTH + 2
// pipelined restoring-division stages, one quotient bit each, nine lanes wide.
// Each stage holds its item only while the next is full, so bubbles close up.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
module matrix3_inverse #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mi3_in_if.sink    in_ch,
  mi3_out_if.source out_ch
);
  import mi3_pkg::*;

  localparam int E   = ELEM_WIDTH;
  localparam int PW  = 2 * E;             // element product
  localparam int CW  = 2 * E + 1;         // cofactor
  localparam int DW  = 3 * E + 3;         // determinant
  localparam int QB  = E + 2;             // quotient bits of floor(2n/d)
  localparam int N2W = CW + 2 * FRAC_BITS + 1;
  localparam int RH  = N2W - QB;
  localparam int XW  = (RH > DW) ? RH : DW;

  localparam int S_PROD = 0;
  localparam int S_COF  = 1;
  localparam int S_DP   = 2;
  localparam int S_DET  = 3;
  localparam int S_ABS  = 4;
  localparam int S_DIV0 = 5;
  localparam int S_FIN  = S_DIV0 + QB + 1;
  localparam int S_OUT  = S_FIN + 1;
  localparam int NST    = S_OUT + 1;

  typedef struct packed {
    logic [DW-1:0] r;
    logic [QB-1:0] q;
    logic [QB-1:0] nlo;
    logic          neg;
    logic          ovf;
  } lane_t;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  logic signed [E-1:0]  m_in [9];
  logic signed [PW-1:0] prod_r [18];
  logic signed [E-1:0]  mk1_r [3];
  logic signed [CW-1:0] cof2_r [9];
  logic signed [E-1:0]  mk2_r [3];
  logic signed [PW:0]   pl_r [3];
  logic signed [PW:0]   ph_r [3];
  logic signed [CW-1:0] cof3_r [9];
  logic signed [DW-1:0] det_r;
  logic signed [CW-1:0] cof4_r [9];
  logic [DW-1:0]        dmag_r;
  logic                 sing5_r;
  logic [CW-1:0]        cmag_r [9];
  logic                 cneg_r [9];
  lane_t                dv_r [QB+1][9];
  logic [DW-1:0]        dd_r [QB+1];
  logic                 ds_r [QB+1];
  logic [QB-1:0]        qr_r [9];
  logic                 satl_r [9];
  logic                 fneg_r [9];
  logic                 fsing_r;
  logic signed [E-1:0]  res_r [9];
  logic                 osing_r;
  logic                 osat_r;

  // Stage enables: a stage loads when it is empty or its contents move on.
  generate
    for (genvar k = 0; k < NST - 1; k++) begin : g_en
      assign en[k] = !v_r[k] || en[k+1];
    end
  endgenerate
  assign en[NST-1] = !v_r[NST-1] || out_ch.ready;

  assign in_ch.ready = en[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign m_in[0] = in_ch.in_c0_r0;
  assign m_in[1] = in_ch.in_c0_r1;
  assign m_in[2] = in_ch.in_c0_r2;
  assign m_in[3] = in_ch.in_c1_r0;
  assign m_in[4] = in_ch.in_c1_r1;
  assign m_in[5] = in_ch.in_c1_r2;
  assign m_in[6] = in_ch.in_c2_r0;
  assign m_in[7] = in_ch.in_c2_r1;
  assign m_in[8] = in_ch.in_c2_r2;

  // The eighteen element products behind the nine cofactors.
  always_ff @(posedge clk) begin
    if (en[S_PROD]) begin
      for (int i = 0; i < 9; i++) begin
        prod_r[2*i]   <= m_in[COF_TAB[i][0]] * m_in[COF_TAB[i][1]];
        prod_r[2*i+1] <= m_in[COF_TAB[i][2]] * m_in[COF_TAB[i][3]];
      end
      mk1_r[0] <= m_in[0];
      mk1_r[1] <= m_in[3];
      mk1_r[2] <= m_in[6];
    end
  end

  // Cofactors.
  always_ff @(posedge clk) begin
    if (en[S_COF]) begin
      for (int i = 0; i < 9; i++) begin
        cof2_r[i] <= CW'(prod_r[2*i]) - CW'(prod_r[2*i+1]);
      end
      mk2_r <= mk1_r;
    end
  end

  // First-row expansion, each product split into a low and a high part.
  always_ff @(posedge clk) begin
    if (en[S_DP]) begin
      for (int j = 0; j < 3; j++) begin
        pl_r[j] <= mk2_r[j] * $signed({1'b0, cof2_r[j][E-1:0]});
        ph_r[j] <= mk2_r[j] * $signed(cof2_r[j][CW-1:E]);
      end
      cof3_r <= cof2_r;
    end
  end

  // Determinant.
  always_ff @(posedge clk) begin
    if (en[S_DET]) begin
      det_r <= (DW'(ph_r[0]) << E) + DW'(pl_r[0])
             + (DW'(ph_r[1]) << E) + DW'(pl_r[1])
             + (DW'(ph_r[2]) << E) + DW'(pl_r[2]);
      cof4_r <= cof3_r;
    end
  end

  // Magnitudes and signs.
  always_ff @(posedge clk) begin
    if (en[S_ABS]) begin
      dmag_r  <= det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
      sing5_r <= (det_r == '0);
      for (int i = 0; i < 9; i++) begin
        cmag_r[i] <= cof4_r[i][CW-1] ? CW'(-cof4_r[i]) : CW'(cof4_r[i]);
        cneg_r[i] <= cof4_r[i][CW-1] != det_r[DW-1];
      end
    end
  end

  // Divider setup: the numerator is 2*|cof|*2^(2F); the bits above the
  // quotient field seed the remainder, and a seed not below the divisor
  // means the quotient overflows.
  always_ff @(posedge clk) begin
    logic [N2W-1:0] n2;
    if (en[S_DIV0]) begin
      for (int i = 0; i < 9; i++) begin
        n2 = {cmag_r[i], {(2 * FRAC_BITS + 1){1'b0}}};
        dv_r[0][i].r   <= DW'(n2[N2W-1:QB]);
        dv_r[0][i].q   <= '0;
        dv_r[0][i].nlo <= n2[QB-1:0];
        dv_r[0][i].neg <= cneg_r[i];
        dv_r[0][i].ovf <= XW'(n2[N2W-1:QB]) >= XW'(dmag_r);
      end
      dd_r[0] <= dmag_r;
      ds_r[0] <= sing5_r;
    end
  end

  // Restoring division, one quotient bit per stage.
  generate
    for (genvar s = 0; s < QB; s++) begin : g_div
      always_ff @(posedge clk) begin
        logic [DW:0] rs;
        if (en[S_DIV0+1+s]) begin
          for (int i = 0; i < 9; i++) begin
            rs = {dv_r[s][i].r, dv_r[s][i].nlo[QB-1-s]};
            dv_r[s+1][i].nlo <= dv_r[s][i].nlo;
            dv_r[s+1][i].neg <= dv_r[s][i].neg;
            dv_r[s+1][i].ovf <= dv_r[s][i].ovf;
            if (rs >= {1'b0, dd_r[s]}) begin
              dv_r[s+1][i].r <= DW'(rs - {1'b0, dd_r[s]});
              dv_r[s+1][i].q <= {dv_r[s][i].q[QB-2:0], 1'b1};
            end else begin
              dv_r[s+1][i].r <= rs[DW-1:0];
              dv_r[s+1][i].q <= {dv_r[s][i].q[QB-2:0], 1'b0};
            end
          end
          dd_r[s+1] <= dd_r[s];
          ds_r[s+1] <= ds_r[s];
        end
      end
    end
  endgenerate

  // Rounding to nearest, ties away from zero, and range check.
  localparam logic [QB-1:0] POS_Q = {{(QB-E+1){1'b0}}, {(E-1){1'b1}}};
  localparam logic [QB-1:0] NEG_Q = {{(QB-E){1'b0}}, 1'b1, {(E-1){1'b0}}};

  always_ff @(posedge clk) begin
    logic [QB:0] qs;
    logic [QB-1:0] qr;
    if (en[S_FIN]) begin
      for (int i = 0; i < 9; i++) begin
        qs = {1'b0, dv_r[QB][i].q} + (QB+1)'(1);
        qr = qs[QB:1];
        qr_r[i]   <= qr;
        fneg_r[i] <= dv_r[QB][i].neg;
        satl_r[i] <= dv_r[QB][i].ovf || (dv_r[QB][i].neg ? (qr > NEG_Q) : (qr > POS_Q));
      end
      fsing_r <= ds_r[QB];
    end
  end

  // Output register: sign, clamp and the singular case.
  always_ff @(posedge clk) begin
    logic sat_any;
    if (en[S_OUT]) begin
      sat_any = 1'b0;
      for (int i = 0; i < 9; i++) begin
        if (fsing_r) begin
          res_r[i] <= '0;
        end else if (satl_r[i]) begin
          res_r[i] <= fneg_r[i] ? {1'b1, {(E-1){1'b0}}} : {1'b0, {(E-1){1'b1}}};
        end else begin
          res_r[i] <= fneg_r[i] ? -$signed(qr_r[i][E-1:0]) : $signed(qr_r[i][E-1:0]);
        end
        sat_any = sat_any | satl_r[i];
      end
      osing_r <= fsing_r;
      osat_r  <= sat_any && !fsing_r;
    end
  end

  assign out_ch.valid     = v_r[S_OUT];
  assign out_ch.out_c0_r0 = res_r[0];
  assign out_ch.out_c0_r1 = res_r[1];
  assign out_ch.out_c0_r2 = res_r[2];
  assign out_ch.out_c1_r0 = res_r[3];
  assign out_ch.out_c1_r1 = res_r[4];
  assign out_ch.out_c1_r2 = res_r[5];
  assign out_ch.out_c2_r0 = res_r[6];
  assign out_ch.out_c2_r1 = res_r[7];
  assign out_ch.out_c2_r2 = res_r[8];
  assign out_ch.singular  = osing_r;
  assign out_ch.saturated = osat_r;

  // A singular result carries zero elements and no saturation.
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.singular) |-> (!out_ch.saturated && res_r[0] == '0
      && res_r[4] == '0 && res_r[8] == '0))
    else $error("singular result not cleared");

  // The input is refused only while the first stage is occupied.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> v_r[S_PROD])
    else $error("input refused with empty first stage");

  // A result waiting on the sink stays in the output register.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(res_r[0])))
    else $error("waiting result lost");

endmodule
`default_nettype wire

@@ bench/matrix3_inverse_tb.sv @@
`timescale 1ns / 1ps
module matrix3_inverse_tb;
  import mi3_pkg::*;

  localparam int EW = ELEM_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int RANDOM_COUNT = 1400;
  localparam int QUIET_TAIL = 200;
  localparam int DRAIN_CYCLES = EW + 30;
  localparam logic [EW-1:0] ONE = EW'(1) << FB;

  // Matrix kinds for the random part.
  typedef enum int {
    KIND_FULL, KIND_MODEST, KIND_DIAG, KIND_SINGULAR, KIND_TINY
  } mat_kind_t;

  typedef struct {
    logic [EW-1:0] e [9];
  } matrix_t;

  typedef struct {
    logic [EW-1:0] e [9];
    logic          singular;
    logic          saturated;
  } inverse_t;

  logic clk;
  logic rst_n;

  mi3_in_if  #(.ELEM_WIDTH(EW)) in_ch ();
  mi3_out_if #(.ELEM_WIDTH(EW)) out_ch ();

  matrix3_inverse #(.ELEM_WIDTH(EW), .FRAC_BITS(FB)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  matrix_t  pending_matrices [$];
  inverse_t expected_inverses [$];
  int       matrices_sent;
  int       inverses_seen;
  int       total_matrices;
  bit       stimulus_done;
  int       error_count;

  // Clock with a 4 ns period.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Exact inverse by the adjugate, rounded to nearest with ties away from zero.
  function automatic inverse_t invert3(matrix_t m);
    logic signed [127:0] ext [9];
    logic signed [127:0] cof [9];
    logic signed [127:0] det;
    logic [127:0] dmag;
    logic [127:0] num;
    logic [127:0] quo;
    logic [127:0] rem;
    logic neg;
    inverse_t res;
    for (int i = 0; i < 9; i++) begin
      ext[i] = $signed(m.e[i]);
    end
    for (int i = 0; i < 9; i++) begin
      cof[i] = ext[COF_TAB[i][0]] * ext[COF_TAB[i][1]]
             - ext[COF_TAB[i][2]] * ext[COF_TAB[i][3]];
    end
    det = ext[0] * cof[0] + ext[3] * cof[1] + ext[6] * cof[2];
    res.singular = (det == 0);
    res.saturated = 1'b0;
    for (int i = 0; i < 9; i++) begin
      res.e[i] = '0;
    end
    if (det != 0) begin
      dmag = det[127] ? -det : det;
      for (int i = 0; i < 9; i++) begin
        neg = cof[i][127] ^ det[127];
        num = (cof[i][127] ? -cof[i] : cof[i]) << (2 * FB);
        quo = num / dmag;
        rem = num % dmag;
        if ((rem << 1) >= dmag) begin
          quo = quo + 1;
        end
        // Clamp to the signed element range.
        if (!neg && quo > (128'(1) << (EW - 1)) - 1) begin
          quo = (128'(1) << (EW - 1)) - 1;
          res.saturated = 1'b1;
        end
        if (neg && quo > (128'(1) << (EW - 1))) begin
          quo = 128'(1) << (EW - 1);
          res.saturated = 1'b1;
        end
        res.e[i] = neg ? -quo[EW-1:0] : quo[EW-1:0];
      end
    end
    return res;
  endfunction

  function automatic logic [EW-1:0] rand_modest();
    // Within about plus or minus 8.0, with a random fraction.
    return EW'($signed(EW'($urandom_range(0, 2 * (8 << FB)))) - (8 << FB));
  endfunction

  function automatic matrix_t random_matrix(mat_kind_t kind);
    matrix_t m;
    int src;
    int dst;
    bit dbl;
    for (int i = 0; i < 9; i++) begin
      case (kind)
        KIND_FULL: begin
          m.e[i] = $urandom;
        end
        KIND_TINY: begin
          m.e[i] = EW'($signed(EW'($urandom_range(0, 64))) - 32);
        end
        KIND_DIAG: begin
          m.e[i] = (i % 4 == 0) ? ONE * $urandom_range(1, 8) + rand_modest()
                                : EW'($signed(rand_modest()) >>> 2);
        end
        default: begin
          m.e[i] = rand_modest();
        end
      endcase
    end
    // Make one column a scaled copy of another so the determinant vanishes.
    if (kind == KIND_SINGULAR) begin
      src = $urandom_range(0, 2);
      dst = (src + $urandom_range(1, 2)) % 3;
      dbl = ($urandom_range(0, 1) == 1);
      for (int r = 0; r < 3; r++) begin
        m.e[dst * 3 + r] = dbl ? m.e[src * 3 + r] * 2 : -m.e[src * 3 + r];
      end
    end
    return m;
  endfunction

  function automatic matrix_t fill_matrix(logic [EW-1:0] v);
    matrix_t m;
    for (int i = 0; i < 9; i++) begin
      m.e[i] = v;
    end
    return m;
  endfunction

  function automatic matrix_t diag_matrix(logic [EW-1:0] a, logic [EW-1:0] b,
                                          logic [EW-1:0] c);
    matrix_t m;
    m = fill_matrix('0);
    m.e[0] = a;
    m.e[4] = b;
    m.e[8] = c;
    return m;
  endfunction

  // Input driver: offers queued matrices, with random idle bursts.
  int  in_gap_left;
  bit  in_load;
  matrix_t in_next;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        matrix_t got;
        got.e = '{in_ch.in_c0_r0, in_ch.in_c0_r1, in_ch.in_c0_r2,
                  in_ch.in_c1_r0, in_ch.in_c1_r1, in_ch.in_c1_r2,
                  in_ch.in_c2_r0, in_ch.in_c2_r1, in_ch.in_c2_r2};
        expected_inverses.push_back(invert3(got));
        matrices_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        in_load = 1'b0;
        if (in_gap_left > 0) begin
          in_gap_left--;
        end else if (matrices_sent < total_matrices - QUIET_TAIL &&
                     $urandom_range(0, 9) == 0) begin
          in_gap_left = $urandom_range(0, 5);
        end else if (pending_matrices.size() > 0) begin
          in_next = pending_matrices.pop_front();
          in_load = 1'b1;
        end
        in_ch.valid <= in_load;
        if (in_load) begin
          in_ch.in_c0_r0 <= in_next.e[0];
          in_ch.in_c0_r1 <= in_next.e[1];
          in_ch.in_c0_r2 <= in_next.e[2];
          in_ch.in_c1_r0 <= in_next.e[3];
          in_ch.in_c1_r1 <= in_next.e[4];
          in_ch.in_c1_r2 <= in_next.e[5];
          in_ch.in_c2_r0 <= in_next.e[6];
          in_ch.in_c2_r1 <= in_next.e[7];
          in_ch.in_c2_r2 <= in_next.e[8];
        end
      end
    end
  end

  // Result ready: random stalls, plus one long hold-off so the pipeline fills.
  int  out_stall_left;
  int  long_hold_left;
  bit  long_hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall_left = 0;
      long_hold_left = 0;
    end else begin
      if (!long_hold_done && matrices_sent >= 300) begin
        long_hold_done = 1'b1;
        long_hold_left = 300;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_ch.ready <= 1'b0;
      end else if (out_stall_left > 0) begin
        out_stall_left--;
        out_ch.ready <= 1'b0;
      end else if (inverses_seen < total_matrices - QUIET_TAIL &&
                   $urandom_range(0, 9) == 0) begin
        out_stall_left = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker: each transfer against the oldest expected inverse.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      inverse_t want;
      logic [EW-1:0] got [9];
      got = '{out_ch.out_c0_r0, out_ch.out_c0_r1, out_ch.out_c0_r2,
              out_ch.out_c1_r0, out_ch.out_c1_r1, out_ch.out_c1_r2,
              out_ch.out_c2_r0, out_ch.out_c2_r1, out_ch.out_c2_r2};
      inverses_seen++;
      if (expected_inverses.size() == 0) begin
        $error("unexpected result transfer");
        error_count++;
      end else begin
        want = expected_inverses.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== want.e[i]) begin
            $error("out_c%0d_r%0d: expected %h, actual %h", i / 3, i % 3,
                   want.e[i], got[i]);
            error_count++;
          end
        end
        if (out_ch.singular !== want.singular) begin
          $error("singular: expected %b, actual %b", want.singular, out_ch.singular);
          error_count++;
        end
        if (out_ch.saturated !== want.saturated) begin
          $error("saturated: expected %b, actual %b", want.saturated,
                 out_ch.saturated);
          error_count++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    matrix_t m;
    int pick;
    in_ch.valid = 1'b0;
    in_ch.in_c0_r0 = '0;
    in_ch.in_c0_r1 = '0;
    in_ch.in_c0_r2 = '0;
    in_ch.in_c1_r0 = '0;
    in_ch.in_c1_r1 = '0;
    in_ch.in_c1_r2 = '0;
    in_ch.in_c2_r0 = '0;
    in_ch.in_c2_r1 = '0;
    in_ch.in_c2_r2 = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;

    // Directed: identity, zero, extremes, saturation, sign cases, singular.
    pending_matrices.push_back(diag_matrix(ONE, ONE, ONE));
    pending_matrices.push_back(fill_matrix('0));
    pending_matrices.push_back(fill_matrix({1'b0, {(EW - 1){1'b1}}}));
    pending_matrices.push_back(fill_matrix({1'b1, {(EW - 1){1'b0}}}));
    pending_matrices.push_back(diag_matrix({1'b1, {(EW - 1){1'b0}}},
                                           {1'b1, {(EW - 1){1'b0}}},
                                           {1'b0, {(EW - 1){1'b1}}}));
    pending_matrices.push_back(diag_matrix(1, 1, 1));
    pending_matrices.push_back(diag_matrix(-1, 1, 1));
    pending_matrices.push_back(diag_matrix(-ONE, 2 * ONE, ONE / 2));
    pending_matrices.push_back(diag_matrix(3 * ONE, 3 * ONE, 3 * ONE));
    pending_matrices.push_back(diag_matrix(ONE / 2, ONE / 2, ONE / 2));
    pending_matrices.push_back(diag_matrix(ONE / 256, ONE, ONE));
    pending_matrices.push_back(diag_matrix(-(ONE / 256), ONE, ONE));
    m = fill_matrix('0);
    m.e[1] = ONE;
    m.e[3] = ONE;
    m.e[8] = -ONE;
    pending_matrices.push_back(m);
    m = diag_matrix({1'b1, {(EW - 1){1'b0}}}, {1'b0, {(EW - 1){1'b1}}},
                    {1'b1, {(EW - 1){1'b0}}});
    m.e[3] = {1'b0, {(EW - 1){1'b1}}};
    pending_matrices.push_back(m);
    for (int k = 0; k < 5; k++) begin
      pending_matrices.push_back(random_matrix(KIND_SINGULAR));
      pending_matrices.push_back(random_matrix(KIND_TINY));
    end

    // Random part: mostly well-conditioned matrices, with extremes mixed in.
    for (int k = 0; k < RANDOM_COUNT; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        pending_matrices.push_back(random_matrix(KIND_FULL));
      end else if (pick < 55) begin
        pending_matrices.push_back(random_matrix(KIND_MODEST));
      end else if (pick < 80) begin
        pending_matrices.push_back(random_matrix(KIND_DIAG));
      end else if (pick < 90) begin
        pending_matrices.push_back(random_matrix(KIND_SINGULAR));
      end else begin
        pending_matrices.push_back(random_matrix(KIND_TINY));
      end
    end
    total_matrices = pending_matrices.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (matrices_sent == total_matrices && expected_inverses.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_if.sv
hw/rtl/matrix3_inverse.sv
bench/matrix3_inverse_tb.sv
